>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> sv/qmpc_pkg.sv
// ----------------------------------------------------------------------------
// qmpc_pkg
// shared codes and field widths of the masked pixel compositor
// ----------------------------------------------------------------------------
package qmpc_pkg;

   localparam int INDEX_BITS  = 12;
   localparam int SAMPLE_BITS = 16;
   localparam int QA_BITS     = 16;
   localparam int OUT_CNT_BITS = 16;
   localparam int DATA_BITS   = 48;
   localparam int CSR_IDX_BITS = 3;

   // item kinds carried in tuser
   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_READOUT    = 1'b1;

   // composite methods
   localparam logic [1:0] METHOD_AVG = 2'd0;
   localparam logic [1:0] METHOD_MIN = 2'd1;
   localparam logic [1:0] METHOD_MAX = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_METHOD    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VALID_MIN = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VALID_MAX = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_USE_QA    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_QA_MASK   = 3'd4;

   localparam logic signed [SAMPLE_BITS-1:0] NO_VALID_VALUE = -16'sd9999;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX     = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN     = 16'sh8000;
   localparam logic [QA_BITS-1:0]            QA_MASK_RESET  = 16'd14;

endpackage

>>> sv/qa_masked_pixel_compositor.sv
// ----------------------------------------------------------------------------
// qa_masked_pixel_compositor
// per-pixel quality masked temporal composite over a stored tile
// ----------------------------------------------------------------------------
// Input stream req_*: tuser selects accumulate or readout; tdata carries the
// pixel index, a signed sample and its QA word. An accumulate folds a valid
// sample into the pixel entry (sum, minimum or maximum) and gives no result.
// A readout gives one rsp_* transfer with the composite and valid count and
// clears the entry. Configuration goes through csr_*, always ready; the user
// must write it only while the block is idle, the block does not enforce this.
// Items are handled one at a time through a single entry memory with a
// registered read: an accumulate reads, modifies and writes back its entry;
// a readout reads and clears it and forms the result, via the bit-serial
// divider and its sign fix when an average with a nonzero count is formed.
// The result sits in an output register; a new item is accepted while it
// waits, but a readout holds in its last step until the register is free.
// After reset a clearing pass writes every entry to zero, one per cycle, with
// req_tready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qa_masked_pixel_compositor #(
   parameter int TILE_PIXELS = 4096,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] pixel_index, [27:12] sample_value, [43:28] qa_flags, [47:44] zero
   input  logic [qmpc_pkg::DATA_BITS-1:0] req_tdata,
   // [0] operation
   input  logic        req_tuser,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [11:0] out_pixel_index, [27:12] composite_value, [43:28] valid_count,
   // [47:44] zero
   output logic [qmpc_pkg::DATA_BITS-1:0] rsp_tdata,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [qmpc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam int IB = qmpc_pkg::INDEX_BITS;
   localparam int SB = qmpc_pkg::SAMPLE_BITS;
   localparam int QB = qmpc_pkg::QA_BITS;
   localparam int OCB = qmpc_pkg::OUT_CNT_BITS;
   localparam int ADDR_BITS = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
   localparam int ACC_BITS = SB + COUNT_BITS;
   localparam int ENTRY_BITS = ACC_BITS + COUNT_BITS + 1;
   localparam int STEP_BITS = $clog2(ACC_BITS);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TILE_PIXELS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(ACC_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] ACC_POS_LIM = ACC_BITS'(32767);
   localparam logic signed [ACC_BITS-1:0] ACC_NEG_LIM = -ACC_POS_LIM - 1;
   localparam logic [ACC_BITS-1:0] MAG_POS_LIM = ACC_BITS'(32767);
   localparam logic [ACC_BITS-1:0] MAG_NEG_LIM = ACC_BITS'(32768);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_FIX,
      ST_RESULT
   } state_type;

   // configuration
   logic [1:0]           method_ff;
   logic signed [SB-1:0] valid_min_ff;
   logic signed [SB-1:0] valid_max_ff;
   logic                 use_qa_ff;
   logic [QB-1:0]        qa_mask_ff;

   // control and item registers
   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                 op_ff, op_in;
   logic [IB-1:0]        idx_ff, idx_in;
   logic signed [SB-1:0] sample_ff, sample_in;
   logic [QB-1:0]        qa_ff, qa_in;
   logic                 inside_ff, inside_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;

   // divider
   logic [ACC_BITS-1:0]   quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic                  neg_ff, neg_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;

   // result
   logic signed [SB-1:0]  comp_ff, comp_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [qmpc_pkg::DATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;

   // memory
   logic [ENTRY_BITS-1:0] mem [TILE_PIXELS];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic                  mem_we;

   logic                  req_accept;
   logic [IB-1:0]         req_idx;
   logic [IB+ADDR_BITS-1:0] req_idx_wide;
   logic [ADDR_BITS-1:0]  req_addr;
   logic                  req_inside;

   logic signed [ACC_BITS-1:0] rd_acc;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic                  rd_touched;
   logic signed [ACC_BITS-1:0] sample_ext;
   logic signed [ACC_BITS-1:0] new_acc;
   logic                  sample_ok;
   logic [COUNT_BITS:0]   trial;
   logic                  qbit;
   logic [COUNT_BITS+OCB-1:0] cnt_wide;
   logic [OCB-1:0]        cnt_out;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign req_idx      = req_tdata[IB-1:0];
   assign req_idx_wide = {{ADDR_BITS{1'b0}}, req_idx};
   assign req_addr     = req_idx_wide[ADDR_BITS-1:0];
   assign req_inside   = 32'(req_idx) < 32'(TILE_PIXELS);

   assign rd_acc     = rd_data_ff[ACC_BITS-1:0];
   assign rd_cnt     = rd_data_ff[ACC_BITS+COUNT_BITS-1:ACC_BITS];
   assign rd_touched = rd_data_ff[ENTRY_BITS-1];
   assign sample_ext = ACC_BITS'(sample_ff);

   assign sample_ok = (sample_ff >= valid_min_ff) && (sample_ff <= valid_max_ff)
                      && !(use_qa_ff && ((qa_ff & qa_mask_ff) != '0));

   // fold of a valid sample into the stored value
   always_comb begin
      new_acc = rd_acc;
      if (rd_cnt == '0) begin
         new_acc = sample_ext;
      end else begin
         case (method_ff)
            qmpc_pkg::METHOD_AVG: new_acc = rd_acc + sample_ext;
            qmpc_pkg::METHOD_MIN: new_acc = (rd_acc > sample_ext) ? sample_ext : rd_acc;
            default:              new_acc = (rd_acc < sample_ext) ? sample_ext : rd_acc;
         endcase
      end
   end

   // one restoring divide step on the magnitude
   assign trial = {rem_ff, quo_ff[ACC_BITS-1]};
   assign qbit  = trial >= {1'b0, divisor_ff};

   assign cnt_wide = {{OCB{1'b0}}, cnt_ff};
   assign cnt_out  = (|cnt_wide[COUNT_BITS+OCB-1:OCB]) ? '1 : cnt_wide[OCB-1:0];

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      sample_in     = sample_ff;
      qa_in         = qa_ff;
      inside_in     = inside_ff;
      addr_in       = addr_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      neg_in        = neg_ff;
      step_in       = step_ff;
      comp_in       = comp_ff;
      cnt_in        = cnt_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_tuser;
               idx_in    = req_idx;
               sample_in = req_tdata[IB+SB-1:IB];
               qa_in     = req_tdata[IB+SB+QB-1:IB+SB];
               inside_in = req_inside;
               addr_in   = req_addr;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == qmpc_pkg::OP_ACCUMULATE) begin
               mem_we   = inside_ff;
               wr_data  = {1'b1, rd_cnt, rd_acc};
               if (sample_ok && rd_cnt != COUNT_MAX) begin
                  wr_data = {1'b1, rd_cnt + 1'b1, new_acc};
               end
               state_in = ST_IDLE;
            end else begin
               mem_we   = inside_ff;
               wr_data  = '0;
               cnt_in   = inside_ff ? rd_cnt : '0;
               state_in = ST_RESULT;
               if (!inside_ff) begin
                  comp_in = '0;
               end else if (rd_cnt == '0) begin
                  comp_in = rd_touched ? qmpc_pkg::NO_VALID_VALUE : '0;
               end else if (method_ff == qmpc_pkg::METHOD_AVG) begin
                  neg_in     = rd_acc[ACC_BITS-1];
                  quo_in     = rd_acc[ACC_BITS-1] ? -rd_acc : rd_acc;
                  rem_in     = '0;
                  divisor_in = rd_cnt;
                  step_in    = '0;
                  state_in   = ST_DIV;
               end else if (rd_acc > ACC_POS_LIM) begin
                  comp_in = qmpc_pkg::SAMPLE_MAX;
               end else if (rd_acc < ACC_NEG_LIM) begin
                  comp_in = qmpc_pkg::SAMPLE_MIN;
               end else begin
                  comp_in = rd_acc[SB-1:0];
               end
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? COUNT_BITS'(trial - {1'b0, divisor_ff})
                           : trial[COUNT_BITS-1:0];
            quo_in  = {quo_ff[ACC_BITS-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // saturate the signed quotient to the sample range
            if (!neg_ff) begin
               comp_in = (quo_ff > MAG_POS_LIM) ? qmpc_pkg::SAMPLE_MAX : quo_ff[SB-1:0];
            end else begin
               comp_in = (quo_ff > MAG_NEG_LIM) ? qmpc_pkg::SAMPLE_MIN : -quo_ff[SB-1:0];
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0, cnt_out, comp_ff, idx_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      sample_ff    <= sample_in;
      qa_ff        <= qa_in;
      inside_ff    <= inside_in;
      addr_ff      <= addr_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      comp_ff      <= comp_in;
      cnt_ff       <= cnt_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff    <= qmpc_pkg::METHOD_AVG;
         valid_min_ff <= qmpc_pkg::SAMPLE_MIN;
         valid_max_ff <= qmpc_pkg::SAMPLE_MAX;
         use_qa_ff    <= 1'b1;
         qa_mask_ff   <= qmpc_pkg::QA_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            qmpc_pkg::CSR_METHOD:    method_ff    <= csr_data[1:0];
            qmpc_pkg::CSR_VALID_MIN: valid_min_ff <= csr_data;
            qmpc_pkg::CSR_VALID_MAX: valid_max_ff <= csr_data;
            qmpc_pkg::CSR_USE_QA:    use_qa_ff    <= csr_data[0];
            qmpc_pkg::CSR_QA_MASK:   qa_mask_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // pixel entry memory: {touched, count, accumulator}
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[req_addr];
   end

   `ASSERT_NEVER(a_write_vs_accept, clock, reset, mem_we && req_accept)
   `ASSERT_AT(a_div_rem_bound, clock, reset,
              (state_ff != ST_DIV) || (rem_ff < divisor_ff))
   `ASSERT_AT(a_readout_clears, clock, reset,
              !(mem_we && state_ff == ST_EXEC && op_ff == qmpc_pkg::OP_READOUT)
              || (wr_data == '0))
   `ASSERT_AT(a_count_step, clock, reset,
              !(mem_we && state_ff == ST_EXEC && op_ff == qmpc_pkg::OP_ACCUMULATE)
              || (wr_data[ACC_BITS+COUNT_BITS-1:ACC_BITS] == rd_cnt)
              || (wr_data[ACC_BITS+COUNT_BITS-1:ACC_BITS] == rd_cnt + 1'b1))

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the masked pixel compositor against a cycle-free model of its tile
// ----------------------------------------------------------------------------
// A table of directed transfers covers the edge cases first: untouched pixels,
// touched pixels with no valid sample, the QA mask, the sample extremes, the
// rounding of the average, and a method switch while entries are held. Random
// phases follow, each with its own register setting, and they reuse a small
// pool of pixels so that entries build up before they are read out. Every
// readout is checked field by field against the composite that the table or
// the model predicts.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PIXELS          = 4096;
   localparam int unsigned COUNT_LIMIT     = 65535;
   localparam logic [1:0]  METHOD_SPARE    = 2'd3;   // decodes as maximum
   localparam int          SETTLE_CYCLES   = 64;
   localparam int          LONG_STALL      = 400;
   localparam int          ITEMS_PER_PHASE = 160;
   localparam int          NUM_PHASES      = 8;
   localparam int          MAX_REPORTS     = 10;
   localparam bit          BY_TABLE        = 1'b1;
   localparam bit          BY_MODEL        = 1'b0;

   typedef struct packed {
      logic        op;
      logic [11:0] pix;
      logic [15:0] smp;
      logic [15:0] qa;
   } pixel_item_type;

   typedef struct packed {
      logic [11:0] pix;
      logic [15:0] comp;
      logic [15:0] cnt;
   } composite_type;

   typedef struct packed {
      logic        op;
      logic [11:0] pix;
      logic [15:0] smp;
      logic [15:0] qa;
      logic        typed;
      logic [15:0] comp;
      logic [15:0] cnt;
   } step_type;

   typedef struct packed {
      logic [1:0]  method;
      logic [15:0] vmin;
      logic [15:0] vmax;
      logic        use_qa;
      logic [15:0] mask;
   } settings_type;

   localparam logic [qmpc_pkg::CSR_IDX_BITS-1:0] CSR_ORDER [5] =
      '{qmpc_pkg::CSR_METHOD, qmpc_pkg::CSR_VALID_MIN, qmpc_pkg::CSR_VALID_MAX,
        qmpc_pkg::CSR_USE_QA, qmpc_pkg::CSR_QA_MASK};

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [qmpc_pkg::DATA_BITS-1:0]    req_tdata = '0;
   logic                              req_tuser = qmpc_pkg::OP_ACCUMULATE;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [qmpc_pkg::DATA_BITS-1:0]    rsp_tdata;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [qmpc_pkg::CSR_IDX_BITS-1:0] csr_index = qmpc_pkg::CSR_METHOD;
   logic [15:0]                       csr_data = '0;

   // model of the tile and of the registers
   longint             acc_mem     [PIXELS];
   int unsigned        cnt_mem     [PIXELS];
   bit                 touched_mem [PIXELS];
   logic [1:0]         cfg_method  = qmpc_pkg::METHOD_AVG;
   logic signed [15:0] cfg_vmin    = qmpc_pkg::SAMPLE_MIN;
   logic signed [15:0] cfg_vmax    = qmpc_pkg::SAMPLE_MAX;
   logic               cfg_use_qa  = 1'b1;
   logic [15:0]        cfg_qa_mask = qmpc_pkg::QA_MASK_RESET;

   composite_type pending_q [$];

   int send_idle_pct = 8;
   int recv_idle_pct = 69;
   bit stall_go      = 1'b0;
   int fail_count    = 0;
   int n_sent        = 0;
   int n_checked     = 0;
   int n_settings    = 0;

   step_type dir_steps [0:21] = '{
      '{qmpc_pkg::OP_READOUT, 12'd0, 16'd0, 16'h0000, BY_TABLE, 16'd0, 16'd0},
      '{qmpc_pkg::OP_READOUT, 12'd4095, 16'd0, 16'h0000, BY_TABLE, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd5, 16'd100, 16'h0002, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_READOUT, 12'd5, 16'd0, 16'h0000, BY_TABLE,
        qmpc_pkg::NO_VALID_VALUE, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd7, qmpc_pkg::SAMPLE_MAX, 16'h0000, BY_MODEL,
        16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd7, qmpc_pkg::SAMPLE_MAX, 16'h0001, BY_MODEL,
        16'd0, 16'd0},
      '{qmpc_pkg::OP_READOUT, 12'd7, 16'd0, 16'h0000, BY_TABLE,
        qmpc_pkg::SAMPLE_MAX, 16'd2},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd9, qmpc_pkg::SAMPLE_MIN, 16'hFFF1, BY_MODEL,
        16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd9, qmpc_pkg::SAMPLE_MIN, 16'h0000, BY_MODEL,
        16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd9, -16'sd1, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_READOUT, 12'd9, 16'd0, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd4095, 16'd1, 16'h8000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd4095, 16'd2, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd4095, -16'sd4, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_READOUT, 12'd4095, 16'd0, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd100, 16'd5, 16'hFFFF, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd100, 16'd5, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_READOUT, 12'd100, 16'd0, 16'h0000, BY_TABLE, 16'd5, 16'd1},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd200, 16'd30000, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd200, 16'd30000, 16'h0000, BY_MODEL, 16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd201, -16'sd30000, 16'h0000, BY_MODEL,
        16'd0, 16'd0},
      '{qmpc_pkg::OP_ACCUMULATE, 12'd201, -16'sd30000, 16'h0000, BY_MODEL,
        16'd0, 16'd0}
   };

   // sums built in average mode, read out after the switch to maximum
   step_type carry_steps [0:1] = '{
      '{qmpc_pkg::OP_READOUT, 12'd200, 16'd0, 16'h0000, BY_TABLE,
        qmpc_pkg::SAMPLE_MAX, 16'd2},
      '{qmpc_pkg::OP_READOUT, 12'd201, 16'd0, 16'h0000, BY_TABLE,
        qmpc_pkg::SAMPLE_MIN, 16'd2}
   };

   settings_type phase_cfg [0:NUM_PHASES-1] = '{
      '{qmpc_pkg::METHOD_AVG, qmpc_pkg::SAMPLE_MIN, qmpc_pkg::SAMPLE_MAX, 1'b1,
        qmpc_pkg::QA_MASK_RESET},
      '{qmpc_pkg::METHOD_MIN, -16'sd1000, 16'sd5000, 1'b1, 16'h00F0},
      '{qmpc_pkg::METHOD_MAX, qmpc_pkg::SAMPLE_MIN, qmpc_pkg::SAMPLE_MIN, 1'b0, 16'h0000},
      '{METHOD_SPARE, qmpc_pkg::SAMPLE_MIN, qmpc_pkg::SAMPLE_MAX, 1'b0, 16'hFFFF},
      '{qmpc_pkg::METHOD_AVG, 16'sd100, -16'sd100, 1'b1, 16'h0001},
      '{qmpc_pkg::METHOD_AVG, qmpc_pkg::SAMPLE_MAX, qmpc_pkg::SAMPLE_MAX, 1'b1, 16'hFFFF},
      '{qmpc_pkg::METHOD_MIN, qmpc_pkg::SAMPLE_MIN, qmpc_pkg::SAMPLE_MAX, 1'b1, 16'hFFFF},
      '{qmpc_pkg::METHOD_MAX, 16'sd0, qmpc_pkg::SAMPLE_MAX, 1'b1, 16'h8001}
   };

   qa_masked_pixel_compositor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // updates the tile model; returns 1 with the composite when a readout
   function automatic bit fold_item(input pixel_item_type it, output composite_type res);
      bit                 ok;
      int unsigned        n;
      longint             wide;
      logic signed [15:0] s;
      s   = it.smp;
      res = '0;
      n   = cnt_mem[it.pix];
      if (it.op == qmpc_pkg::OP_ACCUMULATE) begin
         ok = (s >= cfg_vmin) && (s <= cfg_vmax);
         if (cfg_use_qa && (it.qa & cfg_qa_mask) != '0) ok = 1'b0;
         touched_mem[it.pix] = 1'b1;
         if (ok && n < COUNT_LIMIT) begin
            if (n == 0) begin
               acc_mem[it.pix] = s;
            end else begin
               case (cfg_method)
                  qmpc_pkg::METHOD_AVG: acc_mem[it.pix] += s;
                  qmpc_pkg::METHOD_MIN: if (s < acc_mem[it.pix]) acc_mem[it.pix] = s;
                  default:              if (s > acc_mem[it.pix]) acc_mem[it.pix] = s;
               endcase
            end
            cnt_mem[it.pix] = n + 1;
         end
         return 1'b0;
      end
      res.pix = it.pix;
      if (n != 0) begin
         // division of longint truncates toward zero
         wide = (cfg_method == qmpc_pkg::METHOD_AVG) ? acc_mem[it.pix] / longint'(n)
                                                     : acc_mem[it.pix];
         if (wide > 32767)       res.comp = qmpc_pkg::SAMPLE_MAX;
         else if (wide < -32768) res.comp = qmpc_pkg::SAMPLE_MIN;
         else                    res.comp = wide[15:0];
      end else if (touched_mem[it.pix]) begin
         res.comp = qmpc_pkg::NO_VALID_VALUE;
      end
      res.cnt             = n[15:0];
      acc_mem[it.pix]     = 0;
      cnt_mem[it.pix]     = 0;
      touched_mem[it.pix] = 1'b0;
      return 1'b1;
   endfunction

   task automatic push_item(input pixel_item_type it, input bit typed,
                            input composite_type typed_res);
      composite_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {4'b0, it.qa, it.smp, it.pix};
      do @(posedge clock); while (!req_tready);
      n_sent++;
      if (fold_item(it, res)) begin
         if (typed) res = typed_res;
         pending_q = {pending_q, res};
      end
   endtask

   // drop the input, wait for all composites, then let trailing accumulates finish
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input settings_type s);
      logic [15:0] vals [5];
      vals = '{16'(s.method), s.vmin, s.vmax, 16'(s.use_qa), s.mask};
      csr_valid <= 1'b1;
      for (int r = 0; r < 5; r++) begin
         csr_index <= CSR_ORDER[r];
         csr_data  <= vals[r];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid   <= 1'b0;
      cfg_method  = s.method;
      cfg_vmin    = s.vmin;
      cfg_vmax    = s.vmax;
      cfg_use_qa  = s.use_qa;
      cfg_qa_mask = s.mask;
      n_settings++;
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_side
      forever begin
         @(posedge clock);
         if (stall_go) begin
            stall_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      composite_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: result for pixel %0d with none pending", $realtime,
                        rsp_tdata[11:0]);
         end else begin
            want = pending_q.pop_front();
            n_checked++;
            if (rsp_tdata[11:0] !== want.pix || rsp_tdata[27:12] !== want.comp ||
                rsp_tdata[43:28] !== want.cnt) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: pixel %0d/%0d composite %0d/%0d count %0d/%0d (got/exp)",
                           $realtime, rsp_tdata[11:0], want.pix,
                           $signed(rsp_tdata[27:12]), $signed(want.comp),
                           rsp_tdata[43:28], want.cnt);
            end
         end
      end
   end

   initial begin : stimulus
      pixel_item_type it;
      logic [11:0]    pool [8];
      settings_type   cur;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_steps[i])
         push_item('{dir_steps[i].op, dir_steps[i].pix, dir_steps[i].smp, dir_steps[i].qa},
                   dir_steps[i].typed, '{dir_steps[i].pix, dir_steps[i].comp, dir_steps[i].cnt});
      quiesce();
      cur = '{qmpc_pkg::METHOD_MAX, cfg_vmin, cfg_vmax, cfg_use_qa, cfg_qa_mask};
      apply_settings(cur);
      foreach (carry_steps[i])
         push_item('{carry_steps[i].op, carry_steps[i].pix, carry_steps[i].smp,
                     carry_steps[i].qa}, carry_steps[i].typed,
                   '{carry_steps[i].pix, carry_steps[i].comp, carry_steps[i].cnt});

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         quiesce();
         apply_settings(phase_cfg[ph]);
         send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 69 : 0;
         recv_idle_pct = (ph < 3) ? 69 : (ph < 6) ? 8 : 0;
         foreach (pool[j]) pool[j] = 12'($urandom);
         pool[7] = ph[0] ? 12'hFFF : 12'h000;
         if (ph == 1) stall_go = 1'b1;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            it.op  = ($urandom_range(99) < 20) ? qmpc_pkg::OP_READOUT
                                               : qmpc_pkg::OP_ACCUMULATE;
            it.pix = ($urandom_range(3) == 0) ? 12'($urandom) : pool[$urandom_range(7)];
            case ($urandom_range(9))
               0:       it.smp = qmpc_pkg::SAMPLE_MIN;
               1:       it.smp = qmpc_pkg::SAMPLE_MAX;
               2:       it.smp = cfg_vmin;
               3:       it.smp = cfg_vmax;
               4:       it.smp = cfg_vmin - 16'd1;
               5:       it.smp = cfg_vmax + 16'd1;
               6, 7:    it.smp = 16'($urandom);
               default: it.smp = 16'($urandom_range(4000)) - 16'd2000;
            endcase
            case ($urandom_range(7))
               0, 1, 2, 3: it.qa = '0;
               4, 5:       it.qa = 16'($urandom);
               6:          it.qa = 16'h0001 << $urandom_range(15);
               default:    it.qa = 16'($urandom) & ~cfg_qa_mask;
            endcase
            push_item(it, BY_MODEL, '0);
         end
      end
      quiesce();

      $display("covered %0d input transfers and %0d checked composites over %0d settings,",
               n_sent, n_checked, n_settings);
      $display("all methods, inverted range, QA on/off, long output stall; %0d mismatches",
               fail_count);
      if (fail_count == 0 && pending_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #(15_000_000);
      $display("timeout with %0d composites still pending", pending_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/qmpc_pkg.sv
sv/qa_masked_pixel_compositor.sv
dv/testbench.sv
